[hdl/bpae_pkg.sv]
package bpae_pkg;

  // fixed field widths
  localparam int OP_W       = 3;
  localparam int BUCKET_W   = 6;
  localparam int PAY_W      = 32;
  localparam int KIND_W     = 3;
  localparam int ENTRY_W    = 6;
  localparam int BIU_W      = 7;
  localparam int AGE_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // parameter defaults and fixed limits
  localparam int POOL_ENTRIES_DEF = 64;
  localparam int HANDLE_BITS_DEF  = 32;
  localparam int MAX_BUCKETS      = 64;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY  = 2'd1;
  localparam logic [BIU_W-1:0]     BIU_RESET    = 7'd64;
  localparam logic [AGE_W-1:0]     EXPIRY_RESET = 11'h708;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_TICK    = 3'd2,
    OP_EVICT   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_ALLOC    = 3'd0,
    K_FAIL     = 3'd1,
    K_RELEASED = 3'd2,
    K_EVICTED  = 3'd3,
    K_NONE     = 3'd4,
    K_NOTHING  = 3'd5,
    K_CLEARED  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_ALLOC_RD,
    CMD_ALLOC_WR,
    CMD_STEP,
    CMD_EV_FREE,
    CMD_HOLD,
    CMD_FINAL
  } cmd_t;

  typedef struct packed {
    logic alloc_ok;
    logic walk_end;
    logic walk_free;
    logic found;
    logic hold_valid;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/bpae_ctrl.sv]
module bpae_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [bpae_pkg::OP_W-1:0]    opcode,
  output logic                         in_stall,
  input  bpae_pkg::dp_status_t         st,
  output bpae_pkg::cmd_t               cmd
);
  import bpae_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_WALK,
    S_EV_FREE,
    S_HOLD,
    S_FINAL
  } state_t;

  state_t state, state_next;
  logic   is_evict, is_evict_next;

  assign in_stall = (state != S_IDLE);

  // command and next state
  always_comb begin
    cmd           = CMD_NONE;
    state_next    = state;
    is_evict_next = is_evict;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd           = CMD_START;
          is_evict_next = (opcode == OP_EVICT);
          case (opcode)
            OP_ALLOC:   state_next = st.alloc_ok ? S_ALLOC_RD : S_FINAL;
            OP_RELEASE: state_next = S_WALK;
            OP_TICK:    state_next = S_WALK;
            OP_EVICT:   state_next = S_WALK;
            OP_CLEAR:   state_next = S_FINAL;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC_RD: begin
        cmd        = CMD_ALLOC_RD;
        state_next = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd        = CMD_ALLOC_WR;
        state_next = S_FINAL;
      end
      S_WALK: begin
        cmd = CMD_STEP;
        if (st.walk_end) begin
          state_next = (is_evict && st.found) ? S_EV_FREE : S_FINAL;
        end else if (st.walk_free) begin
          state_next = S_HOLD;
        end
      end
      S_EV_FREE: begin
        cmd        = CMD_EV_FREE;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!(st.hold_valid && !st.out_free)) begin
          cmd        = CMD_HOLD;
          state_next = is_evict ? S_FINAL : S_WALK;
        end
      end
      S_FINAL: begin
        if (st.out_free) begin
          cmd        = CMD_FINAL;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      is_evict <= 1'b0;
    end else begin
      state    <= state_next;
      is_evict <= is_evict_next;
    end
  end

endmodule

[hdl/bpae_dp.sv]
module bpae_dp #(
  parameter int POOL_ENTRIES = bpae_pkg::POOL_ENTRIES_DEF,
  parameter int HANDLE_BITS  = bpae_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bpae_pkg::cmd_t                 cmd,
  output bpae_pkg::dp_status_t           st,
  input  logic [bpae_pkg::OP_W-1:0]      opcode,
  input  logic [bpae_pkg::BUCKET_W-1:0]  bucket,
  input  logic [bpae_pkg::PAY_W-1:0]     payload,
  input  logic [bpae_pkg::BIU_W-1:0]     nb,
  input  logic [bpae_pkg::AGE_W-1:0]     expiry_limit,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [bpae_pkg::KIND_W-1:0]    kind,
  output logic [bpae_pkg::ENTRY_W-1:0]   entry,
  output logic [bpae_pkg::PAY_W-1:0]     payload_out,
  output logic                           last
);
  import bpae_pkg::*;

  localparam int EW = $clog2(POOL_ENTRIES);
  localparam int CW = EW + 1;
  localparam int HW = (HANDLE_BITS < PAY_W) ? HANDLE_BITS : PAY_W;
  localparam logic [CW-1:0] FULL    = CW'(POOL_ENTRIES);
  localparam logic [EW-1:0] TOP_IDX = EW'(POOL_ENTRIES - 1);

  // per-entry state
  logic [POOL_ENTRIES-1:0] used;
  logic [BUCKET_W-1:0]     ebkt [POOL_ENTRIES];
  logic [EW-1:0]           epos [POOL_ENTRIES];
  logic [AGE_W-1:0]        eage [POOL_ENTRIES];

  // handle memory and free stack
  logic [HW-1:0]           hmem [POOL_ENTRIES];
  logic [HW-1:0]           hq;
  logic [EW-1:0]           smem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] svld;
  logic [EW-1:0]           stk_q;
  logic [CW-1:0]           free_count;

  // item context and walk
  op_t                 op;
  logic [BUCKET_W-1:0] abkt;
  logic [HW-1:0]       apay;
  logic [BIU_W-1:0]    walk_b;
  logic [CW-1:0]       walk_p;
  logic                found;
  logic [EW-1:0]       best;
  logic [AGE_W-1:0]    best_age;
  logic [BUCKET_W-1:0] best_b;
  logic [EW-1:0]       best_p;
  kind_t               pend_kind;
  logic [EW-1:0]       pend_e;

  // staging and output registers
  logic                hold_valid;
  kind_t               hold_kind;
  logic [EW-1:0]       hold_e;
  logic [HW-1:0]       hold_h;
  kind_t               out_kind;
  logic [EW-1:0]       out_e;
  logic [HW-1:0]       out_h;

  logic [POOL_ENTRIES-1:0] match;
  logic                    hit;
  logic [EW-1:0]           hit_e;
  logic [AGE_W-1:0]        hit_age;
  logic                    is_release;
  logic                    walk_end;
  logic                    walk_free;
  logic                    do_free;
  logic [EW-1:0]           free_e;
  logic [BUCKET_W-1:0]     free_b;
  logic [EW-1:0]           free_p;
  logic                    out_free;
  logic                    alloc_ok;
  logic [EW-1:0]           pop_a;
  logic [EW-1:0]           push_a;

  // lookup of the entry at the walk position
  always_comb begin
    hit_e   = '0;
    hit_age = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      match[i] = used[i] && ({1'b0, ebkt[i]} == walk_b) && ({1'b0, epos[i]} == walk_p);
      if (match[i]) begin
        hit_e   = hit_e | EW'(i);
        hit_age = hit_age | eage[i];
      end
    end
  end
  assign hit = |match;

  // walk decisions
  assign is_release = (op == OP_RELEASE);
  assign walk_end   = is_release ? !hit : (walk_b >= nb);
  assign walk_free  = !walk_end && hit &&
                      (is_release || (op == OP_TICK && hit_age >= expiry_limit));
  assign do_free    = (cmd == CMD_STEP && walk_free) || (cmd == CMD_EV_FREE);
  assign free_e     = (cmd == CMD_EV_FREE) ? best : hit_e;
  assign free_b     = (cmd == CMD_EV_FREE) ? best_b : walk_b[BUCKET_W-1:0];
  assign free_p     = (cmd == CMD_EV_FREE) ? best_p : walk_p[EW-1:0];
  assign out_free   = !out_valid || !out_stall;
  assign alloc_ok   = (free_count != '0) && ({1'b0, bucket} < nb);
  assign pop_a      = EW'(free_count - 1'b1);
  assign push_a     = free_count[EW-1:0];

  assign st.alloc_ok   = alloc_ok;
  assign st.walk_end   = walk_end;
  assign st.walk_free  = walk_free;
  assign st.found      = found;
  assign st.hold_valid = hold_valid;
  assign st.out_free   = out_free;

  // entry cells: allocate, free, aging, clear
  always_ff @(posedge clk) begin
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      if (rst) begin
        used[i] <= 1'b0;
      end else if (cmd == CMD_START && opcode == OP_CLEAR) begin
        used[i] <= 1'b0;
      end else if (cmd == CMD_ALLOC_WR) begin
        if (used[i] && ebkt[i] == abkt) begin
          epos[i] <= epos[i] + 1'b1;
        end
        if (EW'(i) == stk_q) begin
          used[i] <= 1'b1;
          ebkt[i] <= abkt;
          epos[i] <= '0;
          eage[i] <= '0;
        end
      end else if (do_free) begin
        if (used[i] && ebkt[i] == free_b && epos[i] > free_p) begin
          epos[i] <= epos[i] - 1'b1;
        end
        if (EW'(i) == free_e) begin
          used[i] <= 1'b0;
        end
      end else if (cmd == CMD_STEP && !walk_end && match[i] && op == OP_TICK) begin
        eage[i] <= eage[i] + 1'b1;
      end
    end
  end

  // free stack: pop read, push write, count
  always_ff @(posedge clk) begin
    if (rst) begin
      svld       <= '0;
      free_count <= FULL;
    end else if (cmd == CMD_START && opcode == OP_CLEAR) begin
      svld       <= '0;
      free_count <= FULL;
    end else if (cmd == CMD_ALLOC_WR) begin
      free_count <= free_count - 1'b1;
    end else if (do_free && free_count < FULL) begin
      svld[push_a] <= 1'b1;
      free_count   <= free_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_free && free_count < FULL) begin
      smem[push_a] <= free_e;
    end
    if (cmd == CMD_ALLOC_RD) begin
      stk_q <= svld[pop_a] ? smem[pop_a] : TOP_IDX - pop_a;
    end
  end

  // handle memory
  always_ff @(posedge clk) begin
    if (cmd == CMD_ALLOC_WR) begin
      hmem[stk_q] <= apay;
    end
    if (do_free) begin
      hq <= hmem[free_e];
    end
  end

  // item context, walk counters, staging and output
  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= OP_ALLOC;
      walk_b     <= '0;
      walk_p     <= '0;
      found      <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // drop the taken result unless a new one loads this cycle
      if (out_valid && !out_stall && cmd != CMD_FINAL && !(cmd == CMD_HOLD && hold_valid)) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        CMD_START: begin
          op     <= op_t'(opcode);
          abkt   <= bucket;
          apay   <= payload[HW-1:0];
          walk_b <= (opcode == OP_RELEASE) ? {1'b0, bucket} : '0;
          walk_p <= '0;
          found  <= 1'b0;
          if (opcode == OP_ALLOC && !alloc_ok) begin
            hold_valid <= 1'b1;
            hold_kind  <= K_FAIL;
            hold_e     <= '0;
            hold_h     <= '0;
          end else if (opcode == OP_CLEAR) begin
            hold_valid <= 1'b1;
            hold_kind  <= K_CLEARED;
            hold_e     <= '0;
            hold_h     <= '0;
          end
        end
        CMD_ALLOC_WR: begin
          hold_valid <= 1'b1;
          hold_kind  <= K_ALLOC;
          hold_e     <= stk_q;
          hold_h     <= '0;
        end
        CMD_STEP: begin
          if (!walk_end) begin
            if (hit) begin
              if (walk_free) begin
                pend_e    <= hit_e;
                pend_kind <= K_RELEASED;
              end else begin
                walk_p <= walk_p + 1'b1;
              end
              // evict candidate: later equal ages win
              if (op == OP_EVICT && hit_age != '0 && (!found || hit_age >= best_age)) begin
                found    <= 1'b1;
                best     <= hit_e;
                best_age <= hit_age;
                best_b   <= walk_b[BUCKET_W-1:0];
                best_p   <= walk_p[EW-1:0];
              end
            end else begin
              walk_b <= walk_b + 1'b1;
              walk_p <= '0;
            end
          end
        end
        CMD_EV_FREE: begin
          pend_e    <= best;
          pend_kind <= K_EVICTED;
        end
        CMD_HOLD: begin
          if (hold_valid) begin
            out_valid <= 1'b1;
            out_kind  <= hold_kind;
            out_e     <= hold_e;
            out_h     <= hold_h;
            last      <= 1'b0;
          end
          hold_valid <= 1'b1;
          hold_kind  <= pend_kind;
          hold_e     <= pend_e;
          hold_h     <= hq;
        end
        CMD_FINAL: begin
          out_valid <= 1'b1;
          last      <= 1'b1;
          if (hold_valid) begin
            out_kind <= hold_kind;
            out_e    <= hold_e;
            out_h    <= hold_h;
          end else begin
            out_kind <= (op == OP_EVICT) ? K_NONE : K_NOTHING;
            out_e    <= '0;
            out_h    <= '0;
          end
          hold_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign kind        = out_kind;
  assign entry       = ENTRY_W'(out_e);
  assign payload_out = PAY_W'(out_h);

endmodule

[hdl/bucketed_pool_with_age_eviction_core.sv]
// Sequencing: an allocate reads the free stack, writes the entry and then registers its result;
// a clear or failed allocate registers its result directly. Release walks its own bucket, tick
// and evict walk every bucket in use, and each freed entry passes through a staging step.
// Throughput: one item at a time, with the walk set by the single-position lookup that the walk
// sequencer steps through each cycle while walking; a freed entry holds the walk in staging.
// Reset: synchronous, active high; empties the pool, refills the free stack and restores
// the register defaults, with no clearing pass.
module bucketed_pool_with_age_eviction_core #(
  parameter int POOL_ENTRIES = bpae_pkg::POOL_ENTRIES_DEF,
  parameter int HANDLE_BITS  = bpae_pkg::HANDLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bpae_pkg::OP_W-1:0]       opcode,
  input  logic [bpae_pkg::BUCKET_W-1:0]   bucket,
  input  logic [bpae_pkg::PAY_W-1:0]      payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpae_pkg::KIND_W-1:0]     kind,
  output logic [bpae_pkg::ENTRY_W-1:0]    entry,
  output logic [bpae_pkg::PAY_W-1:0]      payload_out,
  output logic                            last,
  input  logic                            cfg_we,
  input  logic [bpae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpae_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bpae_pkg::*;

  logic [BIU_W-1:0] buckets_in_use;
  logic [AGE_W-1:0] expiry_limit;
  logic [BIU_W-1:0] nb;
  cmd_t             cmd;
  dp_status_t       st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buckets_in_use <= BIU_RESET;
      expiry_limit   <= EXPIRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUCKETS: buckets_in_use <= cfg_data[BIU_W-1:0];
        REG_EXPIRY:  expiry_limit   <= cfg_data[AGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // buckets walked, capped at the bucket limit
  assign nb = ({2'b00, buckets_in_use} > 9'(MAX_BUCKETS)) ? BIU_W'(MAX_BUCKETS)
                                                           : buckets_in_use;

  bpae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bpae_dp #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .opcode       (opcode),
    .bucket       (bucket),
    .payload      (payload),
    .nb           (nb),
    .expiry_limit (expiry_limit),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .entry        (entry),
    .payload_out  (payload_out),
    .last         (last)
  );

`ifndef SYNTHESIS
  // staging never shifts into a blocked output register
  a_hold_free: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_HOLD |-> !(st.hold_valid && !st.out_free))
    else $error("staged item shifted into a full output register");

  // staging is empty whenever a new item is taken
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !st.hold_valid)
    else $error("new item accepted with a staged result pending");

  // the closing result of an item always carries last
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_FINAL |=> out_valid && last)
    else $error("closing result without last");
`endif

endmodule
